FILE: design/nopm_pkg.sv
// ----------------------------------------------------------------------------
// nopm_pkg
// Shared types and codes for the note-on / note-off pair matcher.
// ----------------------------------------------------------------------------
package nopm_pkg;

    localparam int PITCH_W  = 7;
    localparam int VEL_W    = 7;
    localparam int CHAN_W   = 4;
    localparam int PORT_W   = 8;
    localparam int DATE_W   = 32;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 8;

    // event kinds
    localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

    // result status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_STORED    = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_MATCHED   = 3'd2;
    localparam t_status ST_UNMATCHED = 3'd3;
    localparam t_status ST_PASSED    = 3'd4;

    // one pending note-on as held in the table
    typedef struct packed {
        logic              valid;
        logic [PITCH_W-1:0] pitch;
        logic [CHAN_W-1:0]  chan;
        logic [PORT_W-1:0]  port;
        logic [DATE_W-1:0]  date;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // one result item
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [DATE_W-1:0] start_time;
        logic [DATE_W-1:0] duration;
    } t_result;

endpackage

FILE: design/nopm_ram.sv
// ----------------------------------------------------------------------------
// nopm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module nopm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: design/nopm_ctrl.sv
// ----------------------------------------------------------------------------
// nopm_ctrl
// Sequencer: clears the table, probes it one slot a cycle, writes back the
// claimed or freed slot and keeps the free-slot count.
// ----------------------------------------------------------------------------
module nopm_ctrl #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [nopm_pkg::KIND_W-1:0]    i_kind,
    input  logic [nopm_pkg::PITCH_W-1:0]   i_pitch,
    input  logic [nopm_pkg::VEL_W-1:0]     i_velocity,
    input  logic [nopm_pkg::CHAN_W-1:0]    i_channel,
    input  logic [nopm_pkg::PORT_W-1:0]    i_port,
    input  logic [nopm_pkg::DATE_W-1:0]    i_date,
    // table memory
    output logic                           o_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_waddr,
    output logic [nopm_pkg::ENTRY_W-1:0]   o_wdata,
    output logic                           o_re,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_raddr,
    input  logic [nopm_pkg::ENTRY_W-1:0]   i_rdata,
    // result towards the output register
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output nopm_pkg::t_result              o_res
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_PROBE, S_WRITE, S_DONE} t_state;
    typedef enum logic [1:0] {OP_STORE, OP_SEARCH, OP_PASS} t_op;

    t_state                     r_state;
    t_op                        r_op;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_chk_addr;
    logic [AW-1:0]              r_slot;
    logic [CW-1:0]              r_issued;
    logic [CW-1:0]              r_free;
    logic                       r_pend;
    logic [nopm_pkg::PITCH_W-1:0] r_pitch;
    logic [nopm_pkg::CHAN_W-1:0]  r_chan;
    logic [nopm_pkg::PORT_W-1:0]  r_port;
    logic [nopm_pkg::DATE_W-1:0]  r_date;
    logic [nopm_pkg::DATE_W-1:0]  r_start;
    logic [nopm_pkg::DATE_W-1:0]  r_dur;
    nopm_pkg::t_status          r_status;

    nopm_pkg::t_entry rd_entry;
    nopm_pkg::t_entry wr_entry;
    logic             issue;
    logic             hit;
    logic [AW-1:0]    home;
    t_op              in_op;

    // home slot of the incoming event
    assign home = AW'({i_pitch, i_channel});

    // decode what the incoming item asks for
    always_comb begin
        unique case (i_kind)
            nopm_pkg::KIND_ON:  in_op = (i_velocity != '0) ? OP_STORE : OP_SEARCH;
            nopm_pkg::KIND_OFF: in_op = OP_SEARCH;
            default:            in_op = OP_PASS;
        endcase
    end

    // probe: one read issued per cycle, its data checked in the cycle after
    assign issue    = (r_state == S_PROBE) && (r_issued != CW'(TABLE_DEPTH));
    assign rd_entry = nopm_pkg::t_entry'(i_rdata);

    always_comb begin
        if (r_op == OP_STORE) begin
            hit = r_pend && !rd_entry.valid;
        end else begin
            hit = r_pend && rd_entry.valid && (rd_entry.pitch == r_pitch) &&
                  (rd_entry.chan == r_chan) && (rd_entry.port == r_port);
        end
    end

    // write-back data: a new entry on store, an invalid one on free or clear
    always_comb begin
        wr_entry = '0;
        if (r_state == S_WRITE && r_op == OP_STORE) begin
            wr_entry.valid = 1'b1;
            wr_entry.pitch = r_pitch;
            wr_entry.chan  = r_chan;
            wr_entry.port  = r_port;
            wr_entry.date  = r_date;
        end
    end

    assign o_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign o_waddr = (r_state == S_CLEAR) ? r_addr : r_slot;
    assign o_wdata = wr_entry;
    assign o_re    = issue;
    assign o_raddr = r_addr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.status     = r_status;
        o_res.slot       = nopm_pkg::SLOT_W'(r_slot);
        o_res.start_time = r_start;
        o_res.duration   = r_dur;
    end

    // sequencer with its state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_free   <= CW'(TABLE_DEPTH);
            r_pend   <= 1'b0;
            r_issued <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == AW'(TABLE_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op     <= in_op;
                        r_pitch  <= i_pitch;
                        r_chan   <= i_channel;
                        r_port   <= i_port;
                        r_date   <= i_date;
                        r_addr   <= home;
                        r_issued <= '0;
                        r_pend   <= 1'b0;
                        r_slot   <= '0;
                        r_start  <= '0;
                        r_dur    <= '0;
                        if (in_op == OP_PASS) begin
                            r_status <= nopm_pkg::ST_PASSED;
                            r_state  <= S_DONE;
                        end else if (in_op == OP_STORE && r_free == '0) begin
                            r_status <= nopm_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (issue) begin
                        r_addr     <= r_addr - 1'b1;
                        r_issued   <= r_issued + 1'b1;
                        r_chk_addr <= r_addr;
                    end
                    // a hit ends the probe, so no check is left pending
                    r_pend <= issue && !hit;
                    if (hit) begin
                        r_slot  <= r_chk_addr;
                        r_state <= S_WRITE;
                        if (r_op == OP_SEARCH) begin
                            r_start <= rd_entry.date;
                        end
                    end else if (!issue && !r_pend) begin
                        r_status <= (r_op == OP_STORE) ? nopm_pkg::ST_FULL
                                                       : nopm_pkg::ST_UNMATCHED;
                        r_state  <= S_DONE;
                    end
                end
                S_WRITE: begin
                    if (r_op == OP_STORE) begin
                        r_free   <= r_free - 1'b1;
                        r_status <= nopm_pkg::ST_STORED;
                    end else begin
                        if (r_free != CW'(TABLE_DEPTH)) begin
                            r_free <= r_free + 1'b1;
                        end
                        r_status <= nopm_pkg::ST_MATCHED;
                        r_dur    <= r_date - r_start;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // free count stays within the table
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(TABLE_DEPTH))
        else $error("free slot count above table depth");

    // a store takes exactly one slot
    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_op == OP_STORE) |=> (r_free == $past(r_free) - 1'b1))
        else $error("store did not take one free slot");

    // no probe read while the table is being written
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_re && o_we))
        else $error("probe read during table write");

    // a store is only attempted with a free slot left
    a_store_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_op == OP_STORE) |-> (r_free != '0))
        else $error("store into a full table");
`endif

endmodule

FILE: design/note_on_off_pair_matcher_top.sv
// ----------------------------------------------------------------------------
// note_on_off_pair_matcher_top
// Pairs MIDI note-offs with pending note-ons held in an open-addressed table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_ready carries one MIDI event per item;
//   output channel o_out_valid / i_out_ready carries one result per item.
//   Events are handled one at a time. A pass-through event, or a note-on
//   into a full table, goes straight to its result without probing the table.
//   A note-on or note-off probes the table one slot a cycle, downward
//   from its home slot with wrap-around; the table memory has a single
//   read port with a registered read.
//   o_in_ready rises again in the cycle after a result moves into the
//   output register.
//   After reset a clearing pass writes every slot invalid, one a cycle,
//   and o_in_ready stays low during it.
//   The result sits in an output register; while the receiver stalls,
//   the next event may be accepted and processed, and it waits only
//   when its own result is ready and the register is still occupied.
// ----------------------------------------------------------------------------
module note_on_off_pair_matcher_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [nopm_pkg::KIND_W-1:0]   i_kind,
    input  logic [nopm_pkg::PITCH_W-1:0]  i_pitch,
    input  logic [nopm_pkg::VEL_W-1:0]    i_velocity,
    input  logic [nopm_pkg::CHAN_W-1:0]   i_channel,
    input  logic [nopm_pkg::PORT_W-1:0]   i_port,
    input  logic [nopm_pkg::DATE_W-1:0]   i_date,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [nopm_pkg::STATUS_W-1:0] o_status,
    output logic [nopm_pkg::SLOT_W-1:0]   o_slot,
    output logic [nopm_pkg::DATE_W-1:0]   o_start_time,
    output logic [nopm_pkg::DATE_W-1:0]   o_duration
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                         we;
    logic [AW-1:0]                waddr;
    logic [nopm_pkg::ENTRY_W-1:0] wdata;
    logic                         re;
    logic [AW-1:0]                raddr;
    logic [nopm_pkg::ENTRY_W-1:0] rdata;
    logic                         res_valid;
    logic                         res_ready;
    nopm_pkg::t_result            res;
    logic                         r_out_valid;
    nopm_pkg::t_result            r_out;

    // pending note-on table
    nopm_ram #(
        .WIDTH (nopm_pkg::ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // probe and write-back sequencer
    nopm_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_pitch     (i_pitch),
        .i_velocity  (i_velocity),
        .i_channel   (i_channel),
        .i_port      (i_port),
        .i_date      (i_date),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_re        (re),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register, free when empty or being taken
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out.status;
    assign o_slot       = r_out.slot;
    assign o_start_time = r_out.start_time;
    assign o_duration   = r_out.duration;

endmodule

FILE: sim/note_on_off_pair_matcher_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// note_on_off_pair_matcher_top_tb
// Self-checking bench for the note-on / note-off pair matcher. A queue of
// MIDI events feeds a bursty driver; every accepted event runs through a
// behavioural copy of the pending-note table, and each result item is checked
// field by field against the oldest predicted outcome. Stimulus covers
// collisions, wrap-around probing, duplicate notes, a full table and a long
// receiver stall that backs the block up.
// ----------------------------------------------------------------------------
module note_on_off_pair_matcher_top_tb;

    localparam int DEPTH        = 256;
    localparam int SLOT_MASK    = DEPTH - 1;
    localparam int RANDOM_ITEMS = 1200;
    localparam int FILL_AT      = 500;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 3000;
    localparam int CYCLE_LIMIT  = 2_500_000;

    // kinds the package leaves unnamed
    localparam logic [nopm_pkg::KIND_W-1:0] KIND_OTHER = 2'd2;
    localparam logic [nopm_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [nopm_pkg::KIND_W-1:0]  kind;
        logic [nopm_pkg::PITCH_W-1:0] pitch;
        logic [nopm_pkg::VEL_W-1:0]   velocity;
        logic [nopm_pkg::CHAN_W-1:0]  chan;
        logic [nopm_pkg::PORT_W-1:0]  port;
        logic [nopm_pkg::DATE_W-1:0]  date;
    } t_midi_ev;

    typedef struct packed {
        logic [nopm_pkg::PITCH_W-1:0] pitch;
        logic [nopm_pkg::CHAN_W-1:0]  chan;
        logic [nopm_pkg::PORT_W-1:0]  port;
    } t_note_key;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_in_valid   = 1'b0;
    logic                          o_in_ready;
    logic [nopm_pkg::KIND_W-1:0]   i_kind       = '0;
    logic [nopm_pkg::PITCH_W-1:0]  i_pitch      = '0;
    logic [nopm_pkg::VEL_W-1:0]    i_velocity   = '0;
    logic [nopm_pkg::CHAN_W-1:0]   i_channel    = '0;
    logic [nopm_pkg::PORT_W-1:0]   i_port       = '0;
    logic [nopm_pkg::DATE_W-1:0]   i_date       = '0;
    logic                          o_out_valid;
    logic                          i_out_ready  = 1'b0;
    logic [nopm_pkg::STATUS_W-1:0] o_status;
    logic [nopm_pkg::SLOT_W-1:0]   o_slot;
    logic [nopm_pkg::DATE_W-1:0]   o_start_time;
    logic [nopm_pkg::DATE_W-1:0]   o_duration;

    note_on_off_pair_matcher_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_pitch      (i_pitch),
        .i_velocity   (i_velocity),
        .i_channel    (i_channel),
        .i_port       (i_port),
        .i_date       (i_date),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_slot       (o_slot),
        .o_start_time (o_start_time),
        .o_duration   (o_duration)
    );

    // event queue, outcome queue and open notes as the generator sees them
    t_midi_ev          midi_events_q[$];
    nopm_pkg::t_result match_outcomes_q[$];
    t_note_key         open_notes[$];

    // shadow of the pending-note table
    logic                         pend_valid [DEPTH];
    logic [nopm_pkg::PITCH_W-1:0] pend_pitch [DEPTH];
    logic [nopm_pkg::CHAN_W-1:0]  pend_chan  [DEPTH];
    logic [nopm_pkg::PORT_W-1:0]  pend_port  [DEPTH];
    logic [nopm_pkg::DATE_W-1:0]  pend_date  [DEPTH];
    int                           free_cnt;

    int   fault_cnt     = 0;
    int   outcomes_seen = 0;
    int   cycle_cnt     = 0;
    logic ev_taken      = 1'b0;

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // work out the outcome of one event and update the shadow table
    task automatic predict_pairing(input t_midi_ev ev, output nopm_pkg::t_result res);
        int idx;
        int n;
        bit found;
        res        = '0;
        res.status = nopm_pkg::ST_PASSED;
        idx        = ((int'(ev.pitch) << 4) | int'(ev.chan)) & SLOT_MASK;
        if (ev.kind == nopm_pkg::KIND_ON && ev.velocity != '0) begin
            if (free_cnt == 0) begin
                res.status = nopm_pkg::ST_FULL;
            end else begin
                // first free slot probing downward with wrap
                for (n = 0; n < DEPTH && pend_valid[idx]; n++)
                    idx = (idx - 1) & SLOT_MASK;
                if (!pend_valid[idx]) begin
                    free_cnt--;
                    pend_valid[idx] = 1'b1;
                    pend_pitch[idx] = ev.pitch;
                    pend_chan[idx]  = ev.chan;
                    pend_port[idx]  = ev.port;
                    pend_date[idx]  = ev.date;
                    res.status      = nopm_pkg::ST_STORED;
                    res.slot        = idx[nopm_pkg::SLOT_W-1:0];
                end else begin
                    res.status = nopm_pkg::ST_FULL;
                end
            end
        end else if (ev.kind == nopm_pkg::KIND_ON || ev.kind == nopm_pkg::KIND_OFF) begin
            // search from home slot down, then from the top down
            found = 1'b0;
            for (n = 0; n < DEPTH && !found; n++) begin
                if (pend_valid[idx] && pend_pitch[idx] == ev.pitch &&
                    pend_chan[idx] == ev.chan && pend_port[idx] == ev.port)
                    found = 1'b1;
                else
                    idx = (idx - 1) & SLOT_MASK;
            end
            if (found) begin
                pend_valid[idx] = 1'b0;
                if (free_cnt < DEPTH)
                    free_cnt++;
                res.status     = nopm_pkg::ST_MATCHED;
                res.slot       = idx[nopm_pkg::SLOT_W-1:0];
                res.start_time = pend_date[idx];
                res.duration   = ev.date - pend_date[idx];
            end else begin
                res.status = nopm_pkg::ST_UNMATCHED;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fault_cnt++;
        end
    endtask

    task automatic queue_event(input logic [nopm_pkg::KIND_W-1:0] kind,
                               input logic [nopm_pkg::PITCH_W-1:0] pitch,
                               input logic [nopm_pkg::VEL_W-1:0] vel,
                               input logic [nopm_pkg::CHAN_W-1:0] chan,
                               input logic [nopm_pkg::PORT_W-1:0] port,
                               input logic [nopm_pkg::DATE_W-1:0] date);
        t_midi_ev ev;
        ev.kind     = kind;
        ev.pitch    = pitch;
        ev.velocity = vel;
        ev.chan     = chan;
        ev.port     = port;
        ev.date     = date;
        midi_events_q.push_back(ev);
    endtask

    // crowded keys share one low pitch nibble so home slots collide
    task automatic random_key(input bit crowded, output t_note_key key);
        if (crowded) begin
            key.pitch = {3'($urandom_range(7)), 4'd9};
            key.chan  = nopm_pkg::CHAN_W'($urandom_range(1));
            key.port  = nopm_pkg::PORT_W'($urandom_range(3));
        end else begin
            key.pitch = nopm_pkg::PITCH_W'($urandom_range(127));
            key.chan  = nopm_pkg::CHAN_W'($urandom_range(15));
            key.port  = nopm_pkg::PORT_W'($urandom_range(255));
        end
    endtask

    task automatic open_note(input t_note_key key);
        queue_event(nopm_pkg::KIND_ON, key.pitch, nopm_pkg::VEL_W'($urandom_range(1, 127)),
                    key.chan, key.port, $urandom());
        open_notes.push_back(key);
    endtask

    // end one of the open notes, by key-off or zero-velocity key-on
    task automatic close_open_note();
        int        idx;
        t_note_key key;
        idx = $urandom_range(open_notes.size() - 1);
        key = open_notes[idx];
        open_notes.delete(idx);
        if ($urandom_range(3) == 0)
            queue_event(nopm_pkg::KIND_ON, key.pitch, '0, key.chan, key.port, $urandom());
        else
            queue_event(nopm_pkg::KIND_OFF, key.pitch, nopm_pkg::VEL_W'($urandom_range(127)),
                        key.chan, key.port, $urandom());
    endtask

    // note end for a key that is most likely not pending
    task automatic queue_stray_off(input bit crowded);
        t_note_key key;
        random_key(crowded, key);
        if ($urandom_range(1) == 0)
            queue_event(nopm_pkg::KIND_ON, key.pitch, '0, key.chan, key.port, $urandom());
        else
            queue_event(nopm_pkg::KIND_OFF, key.pitch, nopm_pkg::VEL_W'($urandom_range(127)),
                        key.chan, key.port, $urandom());
    endtask

    // stimulus, reset and end of run
    initial begin : stimulus
        t_note_key key;
        int        dice;
        int        counted;
        bit        filled;

        foreach (pend_valid[i]) pend_valid[i] = 1'b0;
        free_cnt = DEPTH;

        // directed: pass-through of odd kinds at both extremes
        queue_event(KIND_OTHER, 7'd127, 7'd127, 4'd15, 8'd255, 32'hFFFF_FFFF);
        queue_event(KIND_SPARE, 7'd0, 7'd0, 4'd0, 8'd0, 32'h0);
        queue_event(KIND_OTHER, 7'd64, 7'd0, 4'd8, 8'd128, 32'h8000_0000);
        queue_event(KIND_SPARE, 7'd127, 7'd127, 4'd15, 8'd255, 32'hFFFF_FFFF);
        // note-off on an empty table
        queue_event(nopm_pkg::KIND_OFF, 7'd0, 7'd0, 4'd0, 8'd0, 32'h0);
        // home slot 0, a collision that wraps to the top, a duplicate note
        queue_event(nopm_pkg::KIND_ON, 7'd0, 7'd1, 4'd0, 8'd0, 32'hFFFF_FF00);
        queue_event(nopm_pkg::KIND_ON, 7'd16, 7'd127, 4'd0, 8'd0, 32'h5);
        queue_event(nopm_pkg::KIND_ON, 7'd0, 7'd64, 4'd0, 8'd0, 32'hA);
        // first duplicate in search order wins, duration wraps
        queue_event(nopm_pkg::KIND_OFF, 7'd0, 7'd0, 4'd0, 8'd0, 32'h10);
        // zero-velocity key-on ends the second duplicate past the wrap
        queue_event(nopm_pkg::KIND_ON, 7'd0, 7'd0, 4'd0, 8'd0, 32'h14);
        // port differs, then the right port
        queue_event(nopm_pkg::KIND_OFF, 7'd16, 7'd0, 4'd0, 8'd1, 32'h20);
        queue_event(nopm_pkg::KIND_OFF, 7'd16, 7'd127, 4'd0, 8'd0, 32'hFFFF_FFFF);
        // top slot
        queue_event(nopm_pkg::KIND_ON, 7'd127, 7'd127, 4'd15, 8'd255, 32'hFFFF_FFFF);
        queue_event(nopm_pkg::KIND_OFF, 7'd127, 7'd0, 4'd15, 8'd255, 32'h0);
        // channel differs, then the right channel
        queue_event(nopm_pkg::KIND_ON, 7'd5, 7'd42, 4'd3, 8'd7, 32'h1234_5678);
        queue_event(nopm_pkg::KIND_OFF, 7'd5, 7'd0, 4'd4, 8'd7, 32'h2234_5678);
        queue_event(nopm_pkg::KIND_OFF, 7'd5, 7'd0, 4'd3, 8'd7, 32'h2234_5678);

        // random: well-formed note pairs with noise, one full-table episode
        counted = 0;
        filled  = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (!filled && counted >= FILL_AT) begin
                filled = 1'b1;
                while (open_notes.size() > 0) begin
                    close_open_note();
                    counted++;
                end
                while (open_notes.size() < DEPTH) begin
                    random_key(1'b0, key);
                    open_note(key);
                    counted++;
                end
                // key-ons into a full table
                repeat (4) begin
                    random_key($urandom_range(1), key);
                    queue_event(nopm_pkg::KIND_ON, key.pitch,
                                nopm_pkg::VEL_W'($urandom_range(1, 127)),
                                key.chan, key.port, $urandom());
                    counted++;
                end
                queue_stray_off(1'b0);
                counted++;
                while (open_notes.size() > 0) begin
                    close_open_note();
                    counted++;
                end
            end
            dice = $urandom_range(99);
            if (dice < 40 && open_notes.size() < 48) begin
                random_key($urandom_range(1), key);
                open_note(key);
                counted++;
            end else if (dice < 75 && open_notes.size() > 0) begin
                close_open_note();
                counted++;
            end else if (dice < 88) begin
                queue_stray_off($urandom_range(1));
                counted++;
            end else begin
                queue_event($urandom_range(1) ? KIND_OTHER : KIND_SPARE,
                            nopm_pkg::PITCH_W'($urandom_range(127)),
                            nopm_pkg::VEL_W'($urandom_range(127)),
                            nopm_pkg::CHAN_W'($urandom_range(15)),
                            nopm_pkg::PORT_W'($urandom_range(255)),
                            $urandom());
                counted++;
            end
        end

        // reset
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain, then let any late stray result show up
        while (midi_events_q.size() != 0 || i_in_valid || match_outcomes_q.size() != 0)
            @(posedge i_clk);
        repeat (DEPTH + 16) @(posedge i_clk);
        if (fault_cnt == 0)
            $display("note_on_off_pair_matcher_top verification clean");
        else
            $display("note_on_off_pair_matcher_top verification failed");
        $finish;
    end

    // sender: bursts of items with random gaps between them
    int       burst_left = 0;
    int       gap_left   = 0;
    t_midi_ev drive_ev;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !ev_taken) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            gap_left   <= gap_left - 1;
            i_in_valid <= 1'b0;
        end else if (midi_events_q.size() > 0) begin
            drive_ev   = midi_events_q.pop_front();
            i_kind     <= drive_ev.kind;
            i_pitch    <= drive_ev.pitch;
            i_velocity <= drive_ev.velocity;
            i_channel  <= drive_ev.chan;
            i_port     <= drive_ev.port;
            i_date     <= drive_ev.date;
            i_in_valid <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 16);
                gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: changing stall modes plus one long hold-off
    int       rx_mode      = 0;
    int       rx_mode_left = 0;
    int       hold_left    = 0;
    bit       hold_done    = 1'b0;
    bit [2:0] rx_phase     = '0;

    always @(negedge i_clk) begin
        rx_phase <= rx_phase + 1'b1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && outcomes_seen >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= $urandom_range(3);
                rx_mode_left <= $urandom_range(64, 512);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(1));
                2: i_out_ready <= ($urandom_range(3) == 0);
                default: i_out_ready <= (rx_phase != 3'd7);
            endcase
        end
    end

    // accepted events feed the prediction, result items are checked
    always @(posedge i_clk) begin : watch_ports
        t_midi_ev          seen_ev;
        nopm_pkg::t_result want;
        nopm_pkg::t_result got;
        ev_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            seen_ev.kind     = i_kind;
            seen_ev.pitch    = i_pitch;
            seen_ev.velocity = i_velocity;
            seen_ev.chan     = i_channel;
            seen_ev.port     = i_port;
            seen_ev.date     = i_date;
            predict_pairing(seen_ev, want);
            match_outcomes_q.push_back(want);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            outcomes_seen++;
            if (match_outcomes_q.size() == 0) begin
                $error("result item with no outcome pending: status 0x%0h", o_status);
                fault_cnt++;
            end else begin
                got = match_outcomes_q.pop_front();
                check_field("status", 32'(got.status), 32'(o_status));
                check_field("slot", 32'(got.slot), 32'(o_slot));
                check_field("start_time", got.start_time, o_start_time);
                check_field("duration", got.duration, o_duration);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("note_on_off_pair_matcher_top verification failed");
            $finish;
        end
    end

endmodule
